// ----- hdl/count_dates_after_reference_defines.svh -----
// Assertion macros used by the top level of the date counter.
`ifndef COUNT_DATES_AFTER_REFERENCE_DEFINES_SVH
`define COUNT_DATES_AFTER_REFERENCE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cda assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cda assertion failed");

`endif

// ----- hdl/cda_pkg.sv -----
// Shared constants, types and helper functions of the date counter.
package cda_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned OUT_WIDTH       = 16;
  localparam int unsigned TEXT_LOW_W      = 64;
  localparam int unsigned TEXT_HIGH_W     = 24;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_INDEX_W     = 2;
  // Packed date key: year (14 bits), month (4 bits), day (5 bits).
  localparam int unsigned KEY_W           = 23;

  localparam logic [7:0] CH_DASH = 8'd45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_REF_TEXT_LOW  = 2'd0;
  localparam cfg_index_t REG_REF_TEXT_HIGH = 2'd1;

  // Result of parsing one date.
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
  } date_info_t;

  // Control from the input stage to the counter stage.
  typedef struct packed {
    logic fire;
    logic later;
    logic last;
  } cnt_ctrl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Days in a month; zero for a code that is not a month.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/cda_date_parse.sv -----
// Combinational check and key packing of one DD-MM-YYYY date text.
module cda_date_parse
  import cda_pkg::*;
(
  input  logic [TEXT_LOW_W-1:0]  text_low,
  input  logic [TEXT_HIGH_W-1:0] text_high,
  output date_info_t             info
);

  logic [7:0]  ch [11];
  logic [3:0]  d  [10];
  logic        fmt_ok;
  logic [6:0]  day;
  logic [6:0]  mon;
  logic [13:0] year;
  logic        leap;
  logic        range_ok;

  // Split the text into characters, character 0 lowest.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ch[i] = text_low[8*i +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      ch[8+i] = text_high[8*i +: 8];
    end
    for (int i = 0; i < 10; i++) begin
      d[i] = ch[i][3:0];
    end
  end

  // Layout: digits, dashes at places two and five, and a terminator.
  assign fmt_ok = !is_digit(ch[10]) && (ch[10] != CH_DASH) &&
                  (ch[2] == CH_DASH) && (ch[5] == CH_DASH) &&
                  is_digit(ch[0]) && is_digit(ch[1]) &&
                  is_digit(ch[3]) && is_digit(ch[4]) &&
                  is_digit(ch[6]) && is_digit(ch[7]) &&
                  is_digit(ch[8]) && is_digit(ch[9]);

  // Decimal fields to binary.
  assign day  = ({3'b000, d[0]} * 7'd10) + {3'b000, d[1]};
  assign mon  = ({3'b000, d[3]} * 7'd10) + {3'b000, d[4]};
  assign year = ({10'd0, d[6]} * 14'd1000) + ({10'd0, d[7]} * 14'd100) +
                ({10'd0, d[8]} * 14'd10) + {10'd0, d[9]};
  assign leap = (year[1:0] == 2'b00);

  // Calendar limits.
  assign range_ok = (year != 14'd0) && (mon != 7'd0) && (mon <= 7'd12) &&
                    (day != 7'd0) &&
                    (day <= {2'b00, month_len(mon[3:0], leap)});

  assign info.ok  = fmt_ok && range_ok;
  assign info.key = {year, mon[3:0], day[4:0]};

endmodule

// ----- hdl/cda_counter.sv -----
// Saturating record counter and result register of the date counter.
module cda_counter
  import cda_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cnt_ctrl_t            ctrl,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [OUT_WIDTH-1:0] out_count
);

  logic [COUNT_WIDTH-1:0]           cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [OUT_WIDTH-1:0]             out_count_r, out_count_nxt;
  logic                             inc;
  logic [COUNT_WIDTH-1:0]           cnt_sum;
  logic [OUT_WIDTH+COUNT_WIDTH-1:0] sum_ext;

  // Count a later record unless the counter is full.
  assign inc     = ctrl.fire && ctrl.later && !(&cnt_r);
  assign cnt_sum = cnt_r + {{(COUNT_WIDTH-1){1'b0}}, inc};
  assign sum_ext = {{OUT_WIDTH{1'b0}}, cnt_sum};

  // A last record loads the result register and restarts the count.
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    if (ctrl.fire) begin
      cnt_nxt = cnt_sum;
      if (ctrl.last) begin
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_count_nxt = sum_ext[OUT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

// ----- hdl/count_dates_after_reference.sv -----
// Top level: counts records dated after a configured reference date.
//
//  channel | direction | beat contents                               | handshake
//  in      | input     | date_text_low, date_text_high, is_last      | in_valid / in_ready
//  out     | output    | later_count                                 | out_valid / out_ready
//  cfg     | input     | cfg_index, cfg_wdata                        | cfg_wr_en
//
// One beat is taken every cycle unless the input stalls; a record is parsed and compared
// in the input register, and a last record's count is registered in the result register.
// The reference text registers are parsed into a registered key after a register write.
// Reset is synchronous and clears the count, the valid flags and the reference.
// A held result stalls the input only when a last record is waiting behind it.
`include "count_dates_after_reference_defines.svh"

module count_dates_after_reference
  import cda_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TEXT_LOW_W-1:0]  in_date_text_low,
  input  logic [TEXT_HIGH_W-1:0] in_date_text_high,
  input  logic                   in_is_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_WIDTH-1:0]   out_later_count,
  input  logic                   cfg_wr_en,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [TEXT_LOW_W-1:0]  ref_low_r, ref_low_nxt;
  logic [TEXT_HIGH_W-1:0] ref_high_r, ref_high_nxt;
  date_info_t             ref_info_r, ref_info_nxt;
  date_info_t             date_info;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [TEXT_LOW_W-1:0]  s1_low_r;
  logic [TEXT_HIGH_W-1:0] s1_high_r;
  logic                   s1_last_r;
  logic                   s1_fire;
  logic                   in_fire;
  cnt_ctrl_t              ctrl;

  // Configuration writes; unknown indexes are dropped.
  always_comb begin
    ref_low_nxt  = ref_low_r;
    ref_high_nxt = ref_high_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_REF_TEXT_LOW:  ref_low_nxt  = cfg_wdata;
        REG_REF_TEXT_HIGH: ref_high_nxt = cfg_wdata[TEXT_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_low_r  <= '0;
      ref_high_r <= '0;
      ref_info_r <= '0;
    end else begin
      ref_low_r  <= ref_low_nxt;
      ref_high_r <= ref_high_nxt;
      ref_info_r <= ref_info_nxt;
    end
  end

  // Reference date parser, registered into ref_info_r.
  cda_date_parse u_ref_parse (
    .text_low  (ref_low_r),
    .text_high (ref_high_r),
    .info      (ref_info_nxt)
  );

  // Input register: a beat leaves unless it is a last record facing a full result.
  assign s1_fire      = s1_valid_r && (!s1_last_r || !out_valid || out_ready);
  assign in_ready     = !s1_valid_r || s1_fire;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_low_r  <= in_date_text_low;
      s1_high_r <= in_date_text_high;
      s1_last_r <= in_is_last;
    end
  end

  // Record date parser and comparison with the reference.
  cda_date_parse u_date_parse (
    .text_low  (s1_low_r),
    .text_high (s1_high_r),
    .info      (date_info)
  );

  assign ctrl.fire  = s1_fire;
  assign ctrl.later = date_info.ok && ref_info_r.ok && (date_info.key > ref_info_r.key);
  assign ctrl.last  = s1_last_r;

  cda_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_count (out_later_count)
  );

  // A last record always produces a result in the next cycle.
  `CDA_ASSERT_NXT(a_last_gives_result, s1_fire && s1_last_r, out_valid)
  // A plain record never creates a result out of an empty output.
  `CDA_ASSERT_NXT(a_plain_no_result, s1_fire && !s1_last_r && !out_valid, !out_valid)
  // The input stalls only behind a last record blocked by an unread result.
  `CDA_ASSERT_IMP(a_stall_cause, !in_ready,
                  s1_valid_r && s1_last_r && out_valid && !out_ready)

endmodule

// ----- tb/count_dates_after_reference_test.sv -----
// Self-checking testbench for the date counter: directed, random and long-statement runs.
`timescale 1ns / 1ps

module count_dates_after_reference_test;
  import cda_pkg::*;

  // Register indexes beyond the two references; writes to them must be ignored.
  localparam cfg_index_t REG_SPARE_2 = 2'd2;
  localparam cfg_index_t REG_SPARE_3 = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam int unsigned COUNT_MAX      = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int unsigned PHASE_RECORDS  = 220;
  localparam int unsigned LONG_RECORDS   = 180;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [TEXT_LOW_W-1:0]  in_date_text_low;
  logic [TEXT_HIGH_W-1:0] in_date_text_high;
  logic                   in_is_last;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_WIDTH-1:0]   out_later_count;
  logic                   cfg_wr_en;
  cfg_index_t             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bit          idle_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned ref_d = 15;
  int unsigned ref_m = 6;
  int unsigned ref_y = 2000;
  int unsigned ref_settings = 0;
  int unsigned stall_cycles = 0;

  // Tracks the reference, the running count and the counts owed per statement.
  class later_count_predictor;
    logic [TEXT_LOW_W-1:0]  ref_low;
    logic [TEXT_HIGH_W-1:0] ref_high;
    int unsigned            running;
    logic [OUT_WIDTH-1:0]   pending_counts[$];
    int unsigned            mismatches;
    int unsigned            records;
    int unsigned            results;

    function new();
      ref_low = '0;
      ref_high = '0;
      running = 0;
      mismatches = 0;
      records = 0;
      results = 0;
    endfunction

    function int unsigned month_length(int unsigned mon, int unsigned yr);
      case (mon)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return (yr % 4 == 0) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Returns whether the text is a valid date; key orders dates by year, month, day.
    function bit date_key(input logic [87:0] text, output int unsigned key);
      logic [7:0]  c;
      int unsigned dg[10];
      int unsigned day, mon, yr;
      key = 0;
      c = text[87:80];
      if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH) return 1'b0;
      for (int i = 0; i < 10; i++) begin
        c = text[8*i +: 8];
        if (i == 2 || i == 5) begin
          if (c != CH_DASH) return 1'b0;
          dg[i] = 0;
        end else begin
          if (c < CH_ZERO || c > CH_NINE) return 1'b0;
          dg[i] = c - CH_ZERO;
        end
      end
      day = dg[0] * 10 + dg[1];
      mon = dg[3] * 10 + dg[4];
      yr = dg[6] * 1000 + dg[7] * 100 + dg[8] * 10 + dg[9];
      if (yr == 0 || mon == 0 || mon > 12 || day == 0) return 1'b0;
      if (day > month_length(mon, yr)) return 1'b0;
      key = (yr << 9) | (mon << 5) | day;
      return 1'b1;
    endfunction

    function void write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_REF_TEXT_LOW) ref_low = data;
      else if (idx == REG_REF_TEXT_HIGH) ref_high = data[TEXT_HIGH_W-1:0];
    endfunction

    // An accepted input beat: count it, and close the statement on a last record.
    function void note_record(input logic [87:0] text, input logic last);
      int unsigned rkey, dkey;
      bit          rok, dok;
      rok = date_key({ref_high, ref_low}, rkey);
      dok = date_key(text, dkey);
      records++;
      if (rok && dok && dkey > rkey && running < COUNT_MAX) running++;
      if (last) begin
        pending_counts.push_back(running[OUT_WIDTH-1:0]);
        running = 0;
      end
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // An accepted output beat is compared with the oldest count owed.
    task check_count(input logic [OUT_WIDTH-1:0] got);
      logic [OUT_WIDTH-1:0] want;
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("later_count %0d arrived with no statement closed", got));
        return;
      end
      want = pending_counts.pop_front();
      results++;
      if (got !== want)
        report_mismatch($sformatf("later_count %0d, expected %0d", got, want));
    endtask
  endclass

  later_count_predictor sb = new();

  count_dates_after_reference i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_date_text_low (in_date_text_low),
    .in_date_text_high(in_date_text_high),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_later_count  (out_later_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Text building helpers for the stimulus.
  function automatic logic [7:0] digit(int unsigned v);
    return CH_ZERO + 8'(v % 10);
  endfunction

  function automatic logic [87:0] date_text(int unsigned d, int unsigned m, int unsigned y,
                                            logic [7:0] term);
    logic [87:0] t;
    t[7:0]   = digit(d / 10);
    t[15:8]  = digit(d);
    t[23:16] = CH_DASH;
    t[31:24] = digit(m / 10);
    t[39:32] = digit(m);
    t[47:40] = CH_DASH;
    t[55:48] = digit(y / 1000);
    t[63:56] = digit(y / 100);
    t[71:64] = digit(y / 10);
    t[79:72] = digit(y);
    t[87:80] = term;
    return t;
  endfunction

  function automatic logic [87:0] with_char(logic [87:0] t, int unsigned pos, logic [7:0] ch);
    t[8*pos +: 8] = ch;
    return t;
  endfunction

  function automatic logic [7:0] random_terminator();
    logic [7:0] c;
    do c = 8'($urandom); while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH);
    return c;
  endfunction

  // One of the eight positions that must hold a digit.
  function automatic int unsigned digit_position();
    int unsigned i;
    i = $urandom_range(7);
    return i + (i >= 2) + (i >= 4);
  endfunction

  function automatic logic [87:0] any_valid_date(int unsigned y_lo);
    int unsigned d, m, y;
    y = $urandom_range(9999, y_lo);
    m = $urandom_range(12, 1);
    d = $urandom_range(sb.month_length(m, y), 1);
    return date_text(d, m, y, random_terminator());
  endfunction

  // Mostly well-formed dates, many close to the reference, plus single flaws and noise.
  function automatic logic [87:0] random_record_text();
    int unsigned kind, d, m, y;
    logic [87:0] t;
    logic [7:0]  c;
    kind = $urandom_range(99);
    if (kind < 25) begin
      y = ref_y;
      m = $urandom_range(1) ? ref_m : $urandom_range(12, 1);
      d = $urandom_range(sb.month_length(m, y), 1);
      if (m == ref_m && $urandom_range(3) == 0) d = ref_d;
      return date_text(d, m, y, random_terminator());
    end
    if (kind < 60) return any_valid_date(1);
    if (kind >= 90) return {$urandom, $urandom, 24'($urandom)};
    y = $urandom_range(9999, 1);
    m = $urandom_range(12, 1);
    d = $urandom_range(28, 1);
    t = date_text(d, m, y, random_terminator());
    case ($urandom_range(8))
      0: t[87:80] = $urandom_range(1) ? CH_DASH : digit($urandom_range(9));
      1: begin
        do c = 8'($urandom); while (c == CH_DASH);
        t = with_char(t, $urandom_range(1) ? 2 : 5, c);
      end
      2: t = with_char(t, digit_position(), CH_DASH);
      3: begin
        do c = 8'($urandom); while (c >= CH_ZERO && c <= CH_NINE);
        t = with_char(t, digit_position(), c);
      end
      4: t = date_text(0, m, y, t[87:80]);
      5: t = date_text(d, $urandom_range(1) ? 0 : $urandom_range(99, 13), y, t[87:80]);
      6: t = date_text(d, m, 0, t[87:80]);
      7: t = date_text($urandom_range(99, sb.month_length(m, y) + 1), m, y, t[87:80]);
      default: t = date_text(29, 2, $urandom_range(2499, 0) * 4 + $urandom_range(3, 1),
                             t[87:80]);
    endcase
    return t;
  endfunction

  // Offers one record beat and returns after it is accepted, at a falling edge.
  task automatic send_record(input logic [87:0] t, input logic last);
    while (idle_on && $urandom_range(99) < 26) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_date_text_low = t[63:0];
    in_date_text_high = t[87:64];
    in_is_last = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed count has come back.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_counts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.write_reg(idx, data);
    // The reference key is registered after the text registers take the write.
    repeat (2) @(negedge clk);
  endtask

  // The high register gets junk above bit 23, which the block must drop.
  task automatic set_reference(input logic [87:0] t);
    write_cfg(REG_REF_TEXT_LOW, t[63:0]);
    write_cfg(REG_REF_TEXT_HIGH, {32'($urandom), 8'($urandom), t[87:64]});
    ref_settings++;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = !idle_on || ($urandom_range(99) >= 26);
    end
  end

  // Note accepted records first, then check any accepted count.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_record({in_date_text_high, in_date_text_low}, in_is_last);
      if (out_valid && out_ready)
        sb.check_count(out_later_count);
    end
  end

  // Watchdog on cycles in which no beat moves on any port.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("count_dates_after_reference regression: fail");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    int unsigned d, m, y;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_date_text_low = '0;
    in_date_text_high = '0;
    in_is_last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_REF_TEXT_LOW;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // The reference after reset is all zero and so invalid: nothing counts.
    send_record(date_text(31, 12, 9999, CH_NEWLINE), 1'b0);
    send_record(date_text(1, 1, 1, CH_SPACE), 1'b0);
    send_record(date_text(15, 6, 2000, CH_NEWLINE), 1'b1);
    wait_drained();

    set_reference(date_text(15, 6, 2000, CH_NEWLINE));
    write_cfg(REG_SPARE_2, {$urandom, $urandom});
    write_cfg(REG_SPARE_3, {$urandom, $urandom});

    // Directed: equal, neighbors, extremes, leap days and each kind of flaw.
    send_record(date_text(15, 6, 2000, CH_SPACE), 1'b1);
    send_record(date_text(16, 6, 2000, CH_NEWLINE), 1'b0);
    send_record(date_text(14, 6, 2000, CH_NEWLINE), 1'b0);
    send_record(date_text(1, 1, 1, CH_NEWLINE), 1'b0);
    send_record(date_text(31, 12, 9999, CH_NEWLINE), 1'b0);
    send_record(date_text(29, 2, 2004, CH_NEWLINE), 1'b0);
    send_record(date_text(29, 2, 2001, CH_NEWLINE), 1'b0);
    send_record(date_text(29, 2, 2400, 8'h00), 1'b1);
    send_record(date_text(0, 7, 2001, CH_NEWLINE), 1'b0);
    send_record(date_text(1, 0, 2001, CH_NEWLINE), 1'b0);
    send_record(date_text(1, 13, 2001, CH_NEWLINE), 1'b0);
    send_record(date_text(32, 1, 2001, CH_NEWLINE), 1'b0);
    send_record(date_text(31, 4, 2001, CH_NEWLINE), 1'b0);
    send_record(date_text(1, 1, 0, CH_NEWLINE), 1'b0);
    send_record(date_text(1, 1, 2001, digit(5)), 1'b0);
    send_record(date_text(1, 1, 2001, CH_DASH), 1'b0);
    send_record(with_char(date_text(1, 1, 2001, CH_NEWLINE), 2, 8'h2F), 1'b0);
    send_record(with_char(date_text(1, 1, 2001, CH_NEWLINE), 0, CH_DASH), 1'b0);
    send_record(with_char(date_text(1, 1, 2001, CH_NEWLINE), 7, 8'h61), 1'b1);
    send_record({88{1'b1}}, 1'b1);
    send_record({88{1'b0}}, 1'b1);
    wait_drained();

    // Random phases, one reference setting each, the extremes among them.
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: begin
          ref_d = 1; ref_m = 1; ref_y = 1;
        end
        2: begin
          ref_d = 31; ref_m = 12; ref_y = 9999;
        end
        3: begin
          ref_d = 29; ref_m = 2; ref_y = 2024;
        end
        default: begin
          y = $urandom_range(9999, 1);
          m = $urandom_range(12, 1);
          ref_y = y;
          ref_m = m;
          ref_d = $urandom_range(sb.month_length(m, y), 1);
        end
      endcase
      if (p == 4) set_reference({$urandom, $urandom, 24'($urandom)});
      else set_reference(date_text(ref_d, ref_m, ref_y, random_terminator()));
      // One phase runs with no idling on either side.
      idle_on = (p != 1);
      // In another the output holds off while a run of last records piles up.
      if (p == 3) hold_request = 1'b1;
      for (int i = 0; i < PHASE_RECORDS; i++)
        send_record(random_record_text(),
                    (i == PHASE_RECORDS - 1) || (p == 3 && i < 40) ||
                    ($urandom_range(11) == 0));
      wait_drained();
    end

    // One long statement of records all later than the reference, then a short one.
    idle_on = 1'b1;
    set_reference(date_text(1, 1, 1, CH_NEWLINE));
    for (int i = 0; i < LONG_RECORDS; i++)
      send_record(any_valid_date(2), i == LONG_RECORDS - 1);
    for (int i = 0; i < 6; i++)
      send_record(random_record_text(), i == 5);
    wait_drained();

    if (sb.pending_counts.size() != 0)
      sb.report_mismatch($sformatf("%0d counts never arrived", sb.pending_counts.size()));
    $display("Summary: %0d records, %0d statement counts checked, %0d reference settings,",
             sb.records, sb.results, ref_settings);
    $display("covering malformed dates, leap days, a held output port and a long statement.");
    if (sb.mismatches == 0) begin
      $display("count_dates_after_reference regression: pass");
    end else begin
      $display("count_dates_after_reference regression: fail");
    end
    $finish;
  end

endmodule
